// ===== sv/fbfla_pkg.sv =====
// Shared types and codes for the fixed-block free-list allocator.
package fbfla_pkg;

   // Width of a block index, a count and the link memory data.
   localparam int unsigned IndexWidth = 8;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REINIT = 2'd2,
      OP_NOP    = 2'd3
   } fbfla_op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_NO_FREE = 2'd1,
      STAT_BAD_IDX = 2'd2,
      STAT_UNUSED  = 2'd3
   } fbfla_status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } fbfla_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;  // latch the request word and read the link memory at the head
      logic commit;   // apply the operation and load the response register
   } fbfla_cmd_type;

endpackage

// ===== sv/fbfla_ctrl.sv =====
// Controller state machine and response handshake for the free-list allocator.
module fbfla_ctrl
   import fbfla_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output fbfla_cmd_type cmd
);

   fbfla_state_type state_ff;
   fbfla_state_type state_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            slot_free;

   // The response register can take a new word when empty or drained this cycle.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_EXEC: begin
            cmd.commit = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/fbfla_dpath.sv =====
// Datapath of the free-list allocator: link memory, head, counts and response register.
module fbfla_dpath
   import fbfla_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbfla_cmd_type         cmd,
   input  logic [1:0]            req_opcode,
   input  logic [IndexWidth-1:0] req_block_index,
   input  logic                  csr_write,
   input  logic [IndexWidth-1:0] csr_value,
   output logic [1:0]            rsp_status,
   output logic [IndexWidth-1:0] rsp_granted_index,
   output logic [IndexWidth-1:0] rsp_free_count
);

   localparam int unsigned AddrWidth = $clog2(MAX_BLOCKS);
   localparam logic [IndexWidth-1:0] MaxCount = IndexWidth'(MAX_BLOCKS);
   localparam logic [IndexWidth-1:0] FullCount = {IndexWidth{1'b1}};

   // Link memory; entries whose valid bit is clear read as their index plus one.
   logic [IndexWidth-1:0] link_mem [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] link_valid_ff;
   logic [MAX_BLOCKS-1:0] link_valid_in;
   logic [IndexWidth-1:0] rd_data_ff;
   logic                  rd_valid_ff;
   logic                  wr_en;

   logic [IndexWidth-1:0] block_count_ff;
   logic [IndexWidth-1:0] active_ff;
   logic [IndexWidth-1:0] active_in;
   logic [IndexWidth-1:0] head_ff;
   logic [IndexWidth-1:0] head_in;
   logic [IndexWidth-1:0] total_ff;
   logic [IndexWidth-1:0] total_in;

   fbfla_op_type          op_ff;
   logic [IndexWidth-1:0] idx_ff;

   fbfla_status_type      status_ff;
   fbfla_status_type      status_in;
   logic [IndexWidth-1:0] granted_ff;
   logic [IndexWidth-1:0] granted_in;
   logic [IndexWidth-1:0] count_ff;

   logic [IndexWidth-1:0] link_value;
   logic [IndexWidth-1:0] limited_count;
   logic                  alloc_ok;
   logic                  free_ok;

   assign link_value = rd_valid_ff ? rd_data_ff : head_ff + IndexWidth'(1);
   assign alloc_ok   = (total_ff != '0) && (head_ff < active_ff);
   assign free_ok    = idx_ff < active_ff;

   always_comb begin
      limited_count = block_count_ff;
      if (block_count_ff == '0) begin
         limited_count = IndexWidth'(1);
      end else if (block_count_ff > MaxCount) begin
         limited_count = MaxCount;
      end
   end

   always_comb begin
      active_in     = active_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      link_valid_in = link_valid_ff;
      status_in     = STAT_DONE;
      granted_in    = '0;
      wr_en         = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (alloc_ok) begin
               granted_in = head_ff;
               head_in    = link_value;
               total_in   = total_ff - IndexWidth'(1);
            end else begin
               status_in = STAT_NO_FREE;
            end
         end
         OP_FREE: begin
            if (free_ok) begin
               wr_en   = 1'b1;
               head_in = idx_ff;
               link_valid_in[idx_ff[AddrWidth-1:0]] = 1'b1;
               if (total_ff != FullCount) begin
                  total_in = total_ff + IndexWidth'(1);
               end
            end else begin
               status_in = STAT_BAD_IDX;
            end
         end
         OP_REINIT: begin
            // Clearing every valid bit restores the chain 0, 1, 2 without a clearing pass.
            active_in     = limited_count;
            head_in       = '0;
            total_in      = limited_count;
            link_valid_in = '0;
         end
         OP_NOP: begin
            status_in = STAT_DONE;
         end
         default: begin
            status_in = STAT_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         link_mem[idx_ff[AddrWidth-1:0]] <= head_ff;
      end
      if (cmd.capture) begin
         rd_data_ff  <= link_mem[head_ff[AddrWidth-1:0]];
         rd_valid_ff <= link_valid_ff[head_ff[AddrWidth-1:0]];
         op_ff       <= fbfla_op_type'(req_opcode);
         idx_ff      <= req_block_index;
      end
      if (cmd.commit) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         count_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff  <= '0;
         block_count_ff <= FullCount;
         active_ff      <= MaxCount;
         head_ff        <= '0;
         total_ff       <= MaxCount;
      end else begin
         if (csr_write) begin
            block_count_ff <= csr_value;
         end
         if (cmd.commit) begin
            link_valid_ff <= link_valid_in;
            active_ff     <= active_in;
            head_ff       <= head_in;
            total_ff      <= total_in;
         end
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_free_count    = count_ff;

`ifndef SYNTHESIS
   a_active_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff != '0) && (active_ff <= MaxCount))
      else $error("active block count left its legal range");

   a_alloc_pops: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_ALLOC && alloc_ok)
      |=> (total_ff == $past(total_ff) - IndexWidth'(1)))
      else $error("successful allocate did not decrement the free count");

   a_reinit_chain: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_REINIT)
      |=> (head_ff == '0) && (total_ff == active_ff) && (link_valid_ff == '0))
      else $error("reinitialize did not rebuild the free chain");

   a_free_pushes: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_FREE && free_ok)
      |=> (head_ff == $past(idx_ff)) && (total_ff != '0))
      else $error("free did not push the block onto the head");
`endif

endmodule

// ===== sv/fixed_block_free_list_allocator.sv =====
// Top level of the fixed-block free-list allocator: controller and datapath.
//
// The allocator keeps a pool of up to MAX_BLOCKS equal blocks on a singly linked free
// list whose links sit in an on-chip link memory. Each request word carries an opcode
// (allocate, free, reinitialize, no operation) and, for a free, the block index; each
// request yields exactly one response word with a status, the granted index (zero
// unless an allocate succeeds) and the free count after the operation. Every request
// passes through the idle state, which accepts it and reads the link memory at the
// current head, and then the execute state, which applies the operation and loads the
// response register; a new request is taken only after the last one is applied. The
// apply step waits while the response register still holds a word that has not been
// taken, so a stalled response slows the request side to the rate at which responses
// drain. Reinitialize rebuilds the chain over the block count latched from the CSR port
// (zero is taken as one, values above MAX_BLOCKS as MAX_BLOCKS) in its apply step, since
// per-entry valid bits are cleared at once; there is no clearing pass after reset.
// Double frees are not detected, and the free count saturates at 255. The CSR port is
// always ready and should be written only while no request is in flight.
module fixed_block_free_list_allocator
   import fbfla_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 255
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] block_index
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] granted_index, [15:8] free_count
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // Block count register write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   fbfla_cmd_type         cmd;
   logic [IndexWidth-1:0] granted_index;
   logic [IndexWidth-1:0] free_count;

   // The block count register can be written in any cycle.
   assign csr_ready = 1'b1;

   fbfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   fbfla_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_opcode        (req_tuser),
      .req_block_index   (req_tdata),
      .csr_write         (csr_valid && csr_ready),
      .csr_value         (csr_data),
      .rsp_status        (rsp_tuser),
      .rsp_granted_index (granted_index),
      .rsp_free_count    (free_count)
   );

   assign rsp_tdata = {free_count, granted_index};

endmodule
